// ----- rtl/core/emb_pkg.sv -----
// ----------------------------------------------------------------------------
// emb_pkg
// shared types, constants and register indexes of the 3x3 emboss filter
// ----------------------------------------------------------------------------
package emb_pkg;

	localparam int DEFAULT_MAX_WIDTH = 2048;

	localparam int PIX_W     = 8;
	localparam int ROW_W     = 16;
	localparam int COL_OUT_W = 11;
	localparam int CFG_W_W   = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [CFG_W_W-1:0] RESET_WIDTH  = 12'd640;
	localparam logic [ROW_W-1:0]   RESET_HEIGHT = 16'd480;

	localparam logic [PIX_W-1:0] EMBOSS_BIAS = 8'd128;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	typedef struct packed {
		logic interior;
		logic border;
	} emb_flags_t;

	typedef struct packed {
		logic [PIX_W-1:0] ul;
		logic [PIX_W-1:0] up;
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] right;
		logic [PIX_W-1:0] down;
		logic [PIX_W-1:0] lr;
	} emb_taps_t;

	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
		logic [PIX_W-1:0]     value;
	} emb_res_t;

endpackage

// ----- rtl/core/emb_ram.sv -----
// ----------------------------------------------------------------------------
// emb_ram
// generic single write, single read ram with registered read, read first
// ----------------------------------------------------------------------------
module emb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

// ----- rtl/core/emb_ctr.sv -----
// ----------------------------------------------------------------------------
// emb_ctr
// frame size registers and row and column position counters
// ----------------------------------------------------------------------------
module emb_ctr
	import emb_pkg::*;
#(
	parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 advance,
	output logic [CW-1:0]        col,
	output logic [ROW_W-1:0]     row,
	output emb_flags_t           flags
);

	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int WW = (EW > CFG_W_W) ? EW : CFG_W_W;

	logic [CFG_W_W-1:0] width_q;
	logic [ROW_W-1:0]   height_q;
	logic [CW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;

	logic [WW-1:0]    w_raw;
	logic [WW-1:0]    eff_w;
	logic [ROW_W-1:0] eff_h;
	logic             col_last;
	logic             row_last;

	always_comb begin
		w_raw = WW'(width_q);
		if (w_raw == '0) begin
			eff_w = WW'(1);
		end else if (w_raw > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = w_raw;
		end
		eff_h = (height_q == '0) ? 16'd1 : height_q;
		col = (WW'(col_q) >= eff_w) ? '0 : col_q;
		row = (row_q >= eff_h) ? '0 : row_q;
		col_last = (WW'(col) == eff_w - WW'(1));
		row_last = (row == eff_h - 16'd1);
		flags.interior = (row >= 16'd2) && (col >= CW'(2));
		flags.border = (row == '0) || row_last || (col == '0) || col_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  width_q <= cfg_data[CFG_W_W-1:0];
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (advance) begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row + 16'd1;
				end else begin
					col_q <= col + CW'(1);
					row_q <= row;
				end
			end
		end
	end

endmodule

// ----- rtl/core/emb_kernel.sv -----
// ----------------------------------------------------------------------------
// emb_kernel
// emboss kernel sum over the 3x3 window plus a bias of 128, wrapped to 8 bits
// ----------------------------------------------------------------------------
module emb_kernel
	import emb_pkg::*;
(
	input  emb_taps_t        taps,
	output logic [PIX_W-1:0] value
);

	always_comb begin
		value = EMBOSS_BIAS + taps.right + taps.down + {taps.lr[PIX_W-2:0], 1'b0}
			- {taps.ul[PIX_W-2:0], 1'b0} - taps.up - taps.left;
	end

endmodule

// ----- rtl/core/emb_outbuf.sv -----
// ----------------------------------------------------------------------------
// emb_outbuf
// result register holding up to two results of one pixel, sent in order
// ----------------------------------------------------------------------------
module emb_outbuf
	import emb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  emb_flags_t flags,
	input  emb_res_t   int_res,
	input  emb_res_t   bord_res,
	output logic       can_load,
	output logic       m_tvalid,
	input  logic       m_tready,
	output emb_res_t   m_res,
	output logic       m_tlast
);

	logic [1:0] cnt_q;
	emb_res_t   res0_q;
	emb_res_t   res1_q;
	logic       take;

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tlast  = (cnt_q == 2'd1);
	assign m_res    = res0_q;
	assign take     = m_tvalid && m_tready;
	assign can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= 2'(flags.interior) + 2'(flags.border);
		end else if (take) begin
			cnt_q <= (cnt_q == 2'd2) ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res0_q <= flags.interior ? int_res : bord_res;
			res1_q <= bord_res;
		end else if (take && (cnt_q == 2'd2)) begin
			res0_q <= res1_q;
		end
	end

endmodule

// ----- rtl/core/emboss_3x3_filter.sv -----
// ----------------------------------------------------------------------------
// emboss_3x3_filter
// streaming 3x3 emboss filter on 8-bit grey pixels in raster order
// ----------------------------------------------------------------------------
// pixels enter on the s_ group, one word per pixel, raster order
// results leave on the m_ group; each carries row, column and value, and
// tlast marks the last result caused by one pixel
// border pixels pass through on arrival; interior pixel (r-1,c-1) is sent
// when pixel (r,c) arrives, before any border result of that pixel
// the cfg channel writes image_width (index 0) and image_height (index 1);
// users must write only while idle, not enforced; cfg_ready is always high
// a result reaches m_ through the input register and then the result register;
// the second result of a pair is on m_ in the cycle after the first is taken
// throughput: one pixel per cycle while m_tready is high, allowed by the
// line store, two ram banks of MAX_WIDTH entries each with one read and one
// write port per cycle; a pixel with two results keeps the next one waiting
// reset: counters go to zero, frame size to 640x480; the line store is
// not cleared, a row's contents are used only after they were written
// when m_tready is low the result register holds, one more pixel is taken
// into the input register if it is empty and then s_tready drops
// ----------------------------------------------------------------------------
module emboss_3x3_filter
	import emb_pkg::*;
#(
	parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // grey_pixel
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // out_row, out_col, out_value, zero pad
	output logic                 m_tlast,   // last_in_run
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic              accept;
	logic              advance;
	logic              can_load;
	logic [CW-1:0]     col_cur;
	logic [ROW_W-1:0]  row_cur;
	emb_flags_t        flags_cur;

	logic              valid_s1;
	logic [PIX_W-1:0]  px_s1;
	logic [CW-1:0]     col_s1;
	logic [ROW_W-1:0]  row_s1;
	emb_flags_t        flags_s1;

	logic [PIX_W-1:0]  top_d1_q;
	logic [PIX_W-1:0]  top_d2_q;
	logic [PIX_W-1:0]  mid_d1_q;
	logic [PIX_W-1:0]  mid_d2_q;
	logic [PIX_W-1:0]  prev_px_q;

	logic [PIX_W-1:0]  bank0_rd;
	logic [PIX_W-1:0]  bank1_rd;
	logic [PIX_W-1:0]  top_c;
	logic [PIX_W-1:0]  mid_c;

	emb_taps_t         taps;
	logic [PIX_W-1:0]  kern_value;
	emb_res_t          int_res;
	emb_res_t          bord_res;
	emb_res_t          m_res;

	logic [CW-1:0]           col_m1;
	logic [CW+COL_OUT_W-1:0] col_ext;
	logic [CW+COL_OUT_W-1:0] col_m1_ext;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && can_load;
	assign s_tready  = !valid_s1 || advance;
	assign accept    = s_tvalid && s_tready;

	emb_ctr #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.col       (col_cur),
		.row       (row_cur),
		.flags     (flags_cur)
	);

	// even rows in bank 0, odd rows in bank 1
	emb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_bank0 (
		.clk   (clk),
		.we    (accept && !row_cur[0]),
		.waddr (col_cur),
		.wdata (s_tdata[PIX_W-1:0]),
		.re    (accept),
		.raddr (col_cur),
		.rdata (bank0_rd)
	);

	emb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_bank1 (
		.clk   (clk),
		.we    (accept && row_cur[0]),
		.waddr (col_cur),
		.wdata (s_tdata[PIX_W-1:0]),
		.re    (accept),
		.raddr (col_cur),
		.rdata (bank1_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			top_d1_q  <= '0;
			top_d2_q  <= '0;
			mid_d1_q  <= '0;
			mid_d2_q  <= '0;
			prev_px_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				top_d2_q  <= top_d1_q;
				top_d1_q  <= top_c;
				mid_d2_q  <= mid_d1_q;
				mid_d1_q  <= mid_c;
				prev_px_q <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1    <= s_tdata[PIX_W-1:0];
			col_s1   <= col_cur;
			row_s1   <= row_cur;
			flags_s1 <= flags_cur;
		end
	end

	// same-parity bank holds row r-2, the other row r-1
	assign top_c = row_s1[0] ? bank1_rd : bank0_rd;
	assign mid_c = row_s1[0] ? bank0_rd : bank1_rd;

	always_comb begin
		taps.ul    = top_d2_q;
		taps.up    = top_d1_q;
		taps.left  = mid_d2_q;
		taps.right = mid_c;
		taps.down  = prev_px_q;
		taps.lr    = px_s1;
	end

	emb_kernel u_kernel (
		.taps  (taps),
		.value (kern_value)
	);

	always_comb begin
		col_m1         = col_s1 - CW'(1);
		col_ext        = {{COL_OUT_W{1'b0}}, col_s1};
		col_m1_ext     = {{COL_OUT_W{1'b0}}, col_m1};
		int_res.row    = row_s1 - 16'd1;
		int_res.col    = col_m1_ext[COL_OUT_W-1:0];
		int_res.value  = kern_value;
		bord_res.row   = row_s1;
		bord_res.col   = col_ext[COL_OUT_W-1:0];
		bord_res.value = px_s1;
	end

	emb_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.flags    (flags_s1),
		.int_res  (int_res),
		.bord_res (bord_res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_res    (m_res),
		.m_tlast  (m_tlast)
	);

	assign m_tdata = {5'b0, m_res.value, m_res.col, m_res.row};

`ifndef ASSERT_OFF
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("second result of a pixel missing");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && valid_s1) |-> !s_tready)
		else $error("input taken while result register and input register full");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !can_load) |=> (valid_s1 && $stable(px_s1) && $stable(col_s1)))
		else $error("input register changed while stalled");
`endif

endmodule
